@@ design/i2c_register_access_master_defines.svh @@
// Assertion macros used by the phase sequencer of the register access master RTL.
`ifndef I2C_REGISTER_ACCESS_MASTER_DEFINES_SVH
`define I2C_REGISTER_ACCESS_MASTER_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define I2CRA_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that must hold in the cycle after the trigger.
`define I2CRA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/i2cra_pkg.sv @@
// Types and constants of the I2C register access master.
`default_nettype none

package i2cra_pkg;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_READ  = 2'd2
  } func_t;

  localparam logic [6:0] DEV_ADDR_RST = 7'd104;

  // Phase numbers of the bus schedule, counted from one.
  localparam logic [6:0] PH_IDLE_HIGH   = 7'd1;
  localparam logic [6:0] PH_START       = 7'd2;
  localparam logic [6:0] PH_ADDR_W      = 7'd3;
  localparam logic [6:0] PH_REG         = 7'd21;
  localparam logic [6:0] PH_REG_END     = 7'd38;
  localparam logic [6:0] PH_SECOND      = 7'd39;
  localparam logic [6:0] PH_RESTART_END = 7'd41;
  localparam logic [6:0] PH_ADDR_R      = 7'd42;
  localparam logic [6:0] PH_ADDR_R_END  = 7'd59;
  localparam logic [6:0] PH_RX          = 7'd60;
  localparam logic [6:0] WRITE_PHASES   = 7'd59;
  localparam logic [6:0] READ_PHASES    = 7'd80;

  // Offset within an 18-phase byte slot at which the ack bit begins.
  localparam logic [4:0] SLOT_ACK_OFF   = 5'd16;

  typedef struct packed {
    logic       scl;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       nack_seen;
  } res_t;

endpackage

`default_nettype wire

@@ design/i2cra_chan_if.sv @@
// Request and result channel interfaces of the I2C register access master.
`default_nettype none

interface i2cra_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] reg_addr;
  logic [7:0] write_data;
  logic       sda_in;

  modport source (output valid, output func, output reg_addr, output write_data,
                  output sda_in, input ready);
  modport sink (input valid, input func, input reg_addr, input write_data,
                input sda_in, output ready);
endinterface

interface i2cra_res_if;
  logic       valid;
  logic       ready;
  logic       scl;
  logic       sda_release;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;
  logic       nack_seen;

  modport source (output valid, output scl, output sda_release, output busy_res,
                  output done_res, output read_data, output nack_seen, input ready);
  modport sink (input valid, input scl, input sda_release, input busy_res,
                input done_res, input read_data, input nack_seen, output ready);
endinterface

`default_nettype wire

@@ design/i2cra_phase_engine.sv @@
// Phase sequencer: transaction state and the pin levels of one bus phase.
`default_nettype none
`include "i2c_register_access_master_defines.svh"

module i2cra_phase_engine
  import i2cra_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [6:0] cfg_wdata,
  input  wire logic       accept,
  input  wire logic [1:0] func,
  input  wire logic [7:0] reg_addr,
  input  wire logic [7:0] write_data,
  input  wire logic       sda_in,
  output res_t            res
);

  logic [6:0] dev_addr_r;
  logic [6:0] step_r, step_nxt;
  logic       is_read_r;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] held_reg_r;
  logic [7:0] held_data_r;
  logic [7:0] recv_r, recv_nxt;
  logic       nack_r, nack_nxt;

  logic       start;
  logic       rd;
  logic [7:0] reg_e;
  logic [7:0] data_e;
  logic [6:0] s;
  logic [6:0] last;
  logic [7:0] wa;
  logic [7:0] ra;
  logic [7:0] s_plus2;
  logic [7:0] p_full;
  logic [1:0] p;
  logic [6:0] off_full;
  logic [4:0] off;
  logic [7:0] slot_val;
  logic       slot_en;
  logic       slot_rx;
  logic       high;
  logic [7:0] base;
  logic       scl;
  logic       rel;
  logic       busy;
  logic       done;

  always_comb begin
    start    = (step_r == '0) &&
               ((func == FUNC_WRITE) || (func == FUNC_READ));
    rd       = start ? (func == FUNC_READ) : is_read_r;
    reg_e    = start ? reg_addr : held_reg_r;
    data_e   = start ? write_data : held_data_r;
    s        = start ? PH_IDLE_HIGH : step_r;
    last     = rd ? READ_PHASES : WRITE_PHASES;
    wa       = {dev_addr_r, 1'b0};
    ra       = {dev_addr_r, 1'b1};
    s_plus2  = {1'b0, s} + 8'd2;
    p_full   = s_plus2 - {1'b0, last};
    p        = p_full[1:0];
    off_full = '0;
    slot_val = '0;
    slot_en  = 1'b0;
    slot_rx  = 1'b0;
    base     = shift_r;
    scl      = 1'b1;
    rel      = 1'b1;
    busy     = 1'b0;
    done     = 1'b0;
    shift_nxt = shift_r;
    nack_nxt  = start ? 1'b0 : nack_r;
    recv_nxt  = recv_r;
    step_nxt  = step_r;

    if (s != '0) begin
      if (s == PH_IDLE_HIGH) begin
        rel = 1'b1;
      end else if (s == PH_START) begin
        rel = 1'b0;
      end else if (s_plus2 >= {1'b0, last}) begin
        // Stop condition: SCL low, SCL high with SDA low, then release SDA.
        scl = (p != 2'd0);
        rel = (p == 2'd2);
      end else if (s <= PH_REG_END) begin
        slot_en  = 1'b1;
        off_full = (s >= PH_REG) ? (s - PH_REG) : (s - PH_ADDR_W);
        slot_val = (s < PH_REG) ? wa : reg_e;
      end else if (!rd) begin
        slot_en  = 1'b1;
        off_full = s - PH_SECOND;
        slot_val = data_e;
      end else if (s <= PH_RESTART_END) begin
        // Repeated start.
        scl = (s != PH_SECOND);
        rel = (s != PH_RESTART_END);
      end else if (s <= PH_ADDR_R_END) begin
        slot_en  = 1'b1;
        off_full = s - PH_ADDR_R;
        slot_val = ra;
      end else begin
        slot_en  = 1'b1;
        slot_rx  = 1'b1;
        off_full = s - PH_RX;
      end

      off  = off_full[4:0];
      high = off[0];
      if (slot_en) begin
        scl = high;
        if (off < SLOT_ACK_OFF) begin
          if (slot_rx) begin
            base      = (off == '0) ? 8'd0 : shift_r;
            shift_nxt = high ? {base[6:0], sda_in} : base;
            rel       = 1'b1;
          end else begin
            base      = (off == '0) ? slot_val : shift_r;
            rel       = base[7];
            shift_nxt = high ? {base[6:0], 1'b0} : base;
          end
        end else begin
          rel = 1'b1;
          if (high && !slot_rx && sda_in) begin
            nack_nxt = 1'b1;
          end
        end
      end

      if (s >= last) begin
        done     = 1'b1;
        step_nxt = '0;
        if (rd) begin
          recv_nxt = shift_nxt;
        end
      end else begin
        busy     = 1'b1;
        step_nxt = s + 7'd1;
      end
    end else begin
      off  = '0;
      high = 1'b0;
    end

    res.scl         = scl;
    res.sda_release = rel;
    res.busy_res    = busy;
    res.done_res    = done;
    res.read_data   = recv_nxt;
    res.nack_seen   = nack_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r  <= DEV_ADDR_RST;
      step_r      <= '0;
      is_read_r   <= 1'b0;
      shift_r     <= '0;
      held_reg_r  <= '0;
      held_data_r <= '0;
      recv_r      <= '0;
      nack_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        dev_addr_r <= cfg_wdata;
      end
      if (accept) begin
        step_r      <= step_nxt;
        is_read_r   <= rd;
        shift_r     <= shift_nxt;
        held_reg_r  <= reg_e;
        held_data_r <= data_e;
        recv_r      <= recv_nxt;
        nack_r      <= nack_nxt;
      end
    end
  end

  `I2CRA_ASSERT_ALWAYS(a_step_bound, step_r <= READ_PHASES, "phase step past read length")
  `I2CRA_ASSERT_ALWAYS(a_write_bound, is_read_r || (step_r <= WRITE_PHASES), "write overran")
  `I2CRA_ASSERT_NEXT(a_start_adv, accept && start, step_r == PH_START, "start did not advance")
  `I2CRA_ASSERT_NEXT(a_done_idle, accept && res.done_res, step_r == '0, "done left busy")

endmodule

`default_nettype wire

@@ design/i2cra_out_stage.sv @@
// Result register between the phase sequencer and the result channel.
`default_nettype none

module i2cra_out_stage
  import i2cra_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire res_t res_in,
  output logic      can_push,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      res_out
);

  logic valid_r, valid_nxt;
  res_t data_r;

  always_comb begin
    can_push  = !valid_r || out_ready;
    valid_nxt = push || (valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = data_r;

endmodule

`default_nettype wire

@@ design/i2c_register_access_master.sv @@
// Top level of the I2C register access master, one bus phase per request.
// A request's result is registered and offered on the next cycle.
// Throughput: one request per cycle; the phase sequencer decides each phase in a
// single pass from its step counter, and a request waits only while a result stalls.
// Reset (rst_n, synchronous, active low) idles the bus and sets the address to 104.
`default_nettype none

module i2c_register_access_master
  import i2cra_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [6:0] cfg_wdata,
  i2cra_req_if.sink       in_chan,
  i2cra_res_if.source     out_chan
);

  // A valid request is taken whenever the result register is empty or being drained,
  // so the sequencer only holds still while no request is offered or a finished result waits downstream.
  logic accept;
  logic can_push;
  res_t res_comb;
  res_t res_q;

  assign in_chan.ready = can_push;
  assign accept        = in_chan.valid && can_push;

  // The sequencer holds the transaction state and decides the pin levels of
  // the phase that each accepted request represents.
  i2cra_phase_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .accept     (accept),
    .func       (in_chan.func),
    .reg_addr   (in_chan.reg_addr),
    .write_data (in_chan.write_data),
    .sda_in     (in_chan.sda_in),
    .res        (res_comb)
  );

  // The result register decouples the result channel from the request side.
  i2cra_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .res_in    (res_comb),
    .can_push  (can_push),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .res_out   (res_q)
  );

  assign out_chan.scl         = res_q.scl;
  assign out_chan.sda_release = res_q.sda_release;
  assign out_chan.busy_res    = res_q.busy_res;
  assign out_chan.done_res    = res_q.done_res;
  assign out_chan.read_data   = res_q.read_data;
  assign out_chan.nack_seen   = res_q.nack_seen;

endmodule

`default_nettype wire
